// ----- sv/lpt_pkg.sv -----
package lpt_pkg;

   localparam int SAMPLE_W     = 32;
   localparam int RUN_LENGTH_W = 11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture the incoming transaction
      logic decide;   // classify: restart, append, overflow, replace or search
      logic step;     // one binary-search probe
      logic commit;   // write tail, update count, load response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_search;
      logic found;
      logic out_free;
   } status_type;

endpackage

// ----- sv/lis_patience_tails.sv -----
// Streaming longest strictly increasing subsequence (patience sorting).
//
// req_ channel: one transaction per sample (signed Q16.16) plus start_new,
// which empties the tails table before that sample is placed.
// rsp_ channel: one transaction per request, run_length = length of the
// longest strictly increasing run ending at the sample; overflow = an
// append was needed with the table already holding MAX_DEPTH tails.
//
// One request in flight. A request goes through idle, decide and commit
// when it restarts, appends, overflows or replaces the only tail, and
// through idle, decide, binary-search probes and commit when it replaces
// a tail in a larger table; each probe is a registered RAM read compared
// in the next cycle. req_stall is low only while the controller is idle.
//
// The response sits in an output register; a stalled rsp_ channel holds
// it steady and the block still takes the next request, stopping only at
// the commit of that one until the register frees up.
// Reset (synchronous) clears the tail count and the controller; the RAM
// itself is not cleared since only written entries are ever used.
module lis_patience_tails #(
   parameter int MAX_DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [lpt_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                                    req_start_new,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic        [lpt_pkg::RUN_LENGTH_W-1:0] rsp_run_length,
   output logic                                    rsp_overflow
);

   lpt_pkg::cmd_type    cmd;
   lpt_pkg::status_type status;

   // sequencing: idle -> decide -> search probes -> commit
   lpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // tails RAM, count, search bounds and response register
   lpt_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_sample),
      .req_start_new  (req_start_new),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_run_length (rsp_run_length),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

// ----- sv/lpt_ctrl.sv -----
module lpt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lpt_pkg::status_type status,
   output lpt_pkg::cmd_type    cmd
);

   lpt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lpt_pkg::ST_DECIDE;
            end
         end
         lpt_pkg::ST_DECIDE: begin
            state_in = status.need_search ? lpt_pkg::ST_SEARCH : lpt_pkg::ST_COMMIT;
         end
         lpt_pkg::ST_SEARCH: begin
            if (status.found) begin
               state_in = lpt_pkg::ST_COMMIT;
            end
         end
         lpt_pkg::ST_COMMIT: begin
            if (status.out_free) begin
               state_in = lpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         lpt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         lpt_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
         end
         lpt_pkg::ST_SEARCH: begin
            cmd.step = 1'b1;
         end
         lpt_pkg::ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ----- sv/lpt_datapath.sv -----
module lpt_datapath #(
   parameter int MAX_DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lpt_pkg::cmd_type                      cmd,
   output lpt_pkg::status_type                   status,
   input  logic signed [lpt_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                  req_start_new,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic        [lpt_pkg::RUN_LENGTH_W-1:0] rsp_run_length,
   output logic                                  rsp_overflow
);

   localparam int AW = $clog2(MAX_DEPTH);
   localparam int CW = $clog2(MAX_DEPTH + 1);
   localparam int LW = lpt_pkg::RUN_LENGTH_W;
   localparam int SW = lpt_pkg::SAMPLE_W;

   // tails table: entries below count_ff are always written before read
   logic signed [SW-1:0] mem [MAX_DEPTH];

   logic signed [SW-1:0] sample_ff, last_ff, rd_ff;
   logic                 start_ff;
   logic [CW-1:0]        count_ff, new_count_ff;
   logic [AW-1:0]        lo_ff, hi_ff, mid_ff, pos_ff;
   logic                 wr_ff, ovf_ff;
   logic                 rsp_valid_ff, rsp_ovf_ff;
   logic [LW-1:0]        rsp_len_ff;

   logic                 empty, above, full;
   logic [CW-1:0]        count_m1;
   logic [AW-1:0]        hi0, lo_n, hi_n, mid_n, rd_addr;
   logic [AW:0]          mid_sum;
   logic                 lt;
   logic [CW-1:0]        pos_p1, len_full;
   logic [CW+LW-1:0]     len_wide;

   always_comb begin
      empty    = start_ff || (count_ff == '0);
      above    = sample_ff > last_ff;
      full     = count_ff == CW'(MAX_DEPTH);
      count_m1 = count_ff - CW'(1);
      hi0      = count_m1[AW-1:0];

      // one probe: rd_ff holds tails[mid_ff]
      lt      = rd_ff < sample_ff;
      lo_n    = lt ? AW'(mid_ff + AW'(1)) : lo_ff;
      hi_n    = lt ? hi_ff : mid_ff;
      mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
      mid_n   = mid_sum[AW:1];

      rd_addr = cmd.decide ? (hi0 >> 1) : mid_n;

      pos_p1   = CW'({1'b0, pos_ff}) + CW'(1);
      len_full = ovf_ff ? count_ff : pos_p1;
      len_wide = {{LW{1'b0}}, len_full};

      status.need_search = !empty && !above && (hi0 != '0);
      status.found       = lo_n == hi_n;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (cmd.commit && wr_ff) begin
         mem[pos_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
         start_ff  <= req_start_new;
      end
      if (cmd.decide) begin
         lo_ff  <= '0;
         hi_ff  <= hi0;
         mid_ff <= hi0 >> 1;
         if (empty) begin
            pos_ff       <= '0;
            wr_ff        <= 1'b1;
            ovf_ff       <= 1'b0;
            new_count_ff <= CW'(1);
         end else if (above) begin
            pos_ff       <= count_ff[AW-1:0];
            wr_ff        <= !full;
            ovf_ff       <= full;
            new_count_ff <= full ? count_ff : CW'(count_ff + CW'(1));
         end else begin
            pos_ff       <= '0;
            wr_ff        <= 1'b1;
            ovf_ff       <= 1'b0;
            new_count_ff <= count_ff;
         end
      end
      if (cmd.step) begin
         lo_ff  <= lo_n;
         hi_ff  <= hi_n;
         mid_ff <= mid_n;
         pos_ff <= lo_n;
      end
      if (cmd.commit) begin
         if (wr_ff && (pos_p1 == new_count_ff)) begin
            last_ff <= sample_ff;
         end
         rsp_len_ff <= len_wide[LW-1:0];
         rsp_ovf_ff <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff <= new_count_ff;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_run_length = rsp_len_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule

// ----- sv/lpt_checker.sv -----
module lpt_checker #(
   parameter int MAX_DEPTH = 1024
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [lpt_pkg::RUN_LENGTH_W-1:0]    rsp_run_length,
   input logic                                rsp_overflow
);

   localparam logic [lpt_pkg::RUN_LENGTH_W-1:0] FULL_LEN =
      lpt_pkg::RUN_LENGTH_W'(MAX_DEPTH);
   localparam bit NO_WRAP = MAX_DEPTH < 2048;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_run_length)
                                 && $stable(rsp_overflow))
      else $error("stalled response changed");

   // one request at a time: busy right after a transaction
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // overflow only at a full table
   a_ovf_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_run_length == FULL_LEN)
      else $error("overflow with length other than table depth");

   // length never zero unless the field wraps
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && NO_WRAP |-> rsp_run_length != '0)
      else $error("zero run length");

endmodule

bind lis_patience_tails lpt_checker #(
   .MAX_DEPTH (MAX_DEPTH)
) u_lpt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_run_length (rsp_run_length),
   .rsp_overflow   (rsp_overflow)
);

// ----- tb/lis_patience_tails_checker.sv -----
module lis_patience_tails_checker #(
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic signed [lpt_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                                    req_start_new,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic        [lpt_pkg::RUN_LENGTH_W-1:0] rsp_run_length,
   input  logic                                    rsp_overflow,
   output int                                      fail_count,
   output int                                      pending_count,
   output int                                      checked_count,
   output int                                      overflow_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [lpt_pkg::RUN_LENGTH_W-1:0] run_length;
      logic                             overflow;
   } run_result_type;

   // shadow patience table
   logic signed [lpt_pkg::SAMPLE_W-1:0] tails_mem [DEPTH];
   int                                  tail_count;
   run_result_type                      expected_runs [$];

   initial begin
      fail_count     = 0;
      pending_count  = 0;
      checked_count  = 0;
      overflow_count = 0;
      tail_count     = 0;
   end

   // place one sample in the table, return the run length ending at it
   function automatic run_result_type place_sample(
      input logic signed [lpt_pkg::SAMPLE_W-1:0] value,
      input logic                                restart
   );
      run_result_type r;
      int             lo;
      int             hi;
      int             mid;
      int             len;
      r.overflow = 1'b0;
      if (restart || tail_count == 0) begin
         tails_mem[0] = value;
         tail_count   = 1;
         len          = 1;
      end else if (value > tails_mem[tail_count-1]) begin
         if (tail_count < DEPTH) begin
            tails_mem[tail_count] = value;
            tail_count++;
            len = tail_count;
         end else begin
            len        = tail_count;
            r.overflow = 1'b1;
         end
      end else begin
         // first tail not less than the sample
         lo = 0;
         hi = tail_count;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tails_mem[mid] < value) lo = mid + 1;
            else hi = mid;
         end
         tails_mem[lo] = value;
         len           = lo + 1;
      end
      r.run_length = len[lpt_pkg::RUN_LENGTH_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      run_result_type want;
      if (reset) begin
         tail_count = 0;
         expected_runs.delete();
      end else begin
         // response first: a request taken at this edge cannot answer yet
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (expected_runs.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected transaction run_length=%0d overflow=%0b",
                        $time, rsp_run_length, rsp_overflow);
            end else begin
               want = expected_runs.pop_front();
               if (want.overflow) overflow_count++;
               if (rsp_run_length !== want.run_length) begin
                  fail_count++;
                  $display("%0t: run_length mismatch expected %0d actual %0d",
                           $time, want.run_length, rsp_run_length);
               end
               if (rsp_overflow !== want.overflow) begin
                  fail_count++;
                  $display("%0t: overflow mismatch expected %0b actual %0b",
                           $time, want.overflow, rsp_overflow);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_runs.push_back(place_sample(req_sample, req_start_new));
      end
      pending_count = expected_runs.size();
   end

endmodule

// ----- tb/lis_patience_tails_tb.sv -----
module lis_patience_tails_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 1024;
   localparam int RANDOM_ITEMS = 260;
   localparam int PHASE_LEN    = 64;    // transactions per idling phase
   localparam int DRAIN_LIMIT  = 100000;
   localparam int TAIL_CYCLES  = 40;    // past worst-case latency of one request

   localparam logic signed [lpt_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam logic signed [lpt_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

   // idling modes, rotated every PHASE_LEN transactions
   typedef enum int {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH
   } idle_phase_type;

   // shapes of the random sequences
   typedef enum int {
      KIND_UNIFORM,
      KIND_NARROW,
      KIND_RISING,
      KIND_FALLING,
      KIND_EXTREMES
   } seq_kind_type;

   logic                                    clock;
   logic                                    reset         = 1'b1;
   logic                                    req_valid     = 1'b0;
   logic                                    req_stall;
   logic signed [lpt_pkg::SAMPLE_W-1:0]     req_sample    = '0;
   logic                                    req_start_new = 1'b0;
   logic                                    rsp_valid;
   logic                                    rsp_stall     = 1'b0;
   logic        [lpt_pkg::RUN_LENGTH_W-1:0] rsp_run_length;
   logic                                    rsp_overflow;

   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int sent_count   = 0;
   int seq_count    = 0;

   int fail_count;
   int pending_count;
   int checked_count;
   int overflow_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   lis_patience_tails #(
      .MAX_DEPTH(DEPTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_start_new (req_start_new),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_run_length(rsp_run_length),
      .rsp_overflow  (rsp_overflow)
   );

   lis_patience_tails_checker #(
      .DEPTH(DEPTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_start_new (req_start_new),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_run_length(rsp_run_length),
      .rsp_overflow  (rsp_overflow),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .overflow_count(overflow_count)
   );

   // Receiver back-pressure: a fresh coin every cycle at the current phase's rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_stall_pct);
   end

   // Hand one sample to the block. Random sender gaps come first; valid is
   // only lowered inside a gap, so back-to-back transactions keep it high
   // with a single assignment per edge. Returns at the accepting edge.
   task automatic send_sample(input logic signed [lpt_pkg::SAMPLE_W-1:0] value,
                              input logic                                restart);
      idle_phase_type ph;
      ph = idle_phase_type'((sent_count / PHASE_LEN) % 4);
      case (ph)
         PH_STEADY: begin
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
         end
         PH_SENDER_IDLE: begin
            tx_idle_pct  = 77;
            rx_stall_pct = 0;
         end
         PH_RECEIVER_STALL: begin
            tx_idle_pct  = 0;
            rx_stall_pct = 77;
         end
         default: begin
            tx_idle_pct  = 23;
            rx_stall_pct = 23;
         end
      endcase
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample    <= value;
      req_start_new <= restart;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // Fill the table to the brim with a strictly rising run, then push past
   // it: samples above the last tail must saturate and flag overflow, the
   // rest exercise the full ten-probe search on a full table.
   task automatic fill_to_overflow();
      logic signed [lpt_pkg::SAMPLE_W-1:0] value;
      int                                  k;
      value = SAMPLE_MIN;
      send_sample(value, 1'b1);
      for (k = 1; k < DEPTH; k++) begin
         value = value + int'($urandom_range(1 << 21, 1));
         send_sample(value, 1'b0);
      end
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      for (k = 0; k < 16; k++)
         send_sample($urandom(), 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      seq_count++;
   endtask

   // One random sequence. Most begin with start_new; a few carry on from the
   // previous table, and a rare mid-sequence restart adds noise.
   task automatic random_sequence();
      seq_kind_type                        kind;
      int                                  len;
      int                                  k;
      int                                  base;
      logic signed [lpt_pkg::SAMPLE_W-1:0] value;
      logic                                restart;
      kind = seq_kind_type'($urandom_range(4));
      // mostly short runs, now and then a long one for a deep table
      len  = ($urandom_range(9) == 0) ? $urandom_range(300, 80) : $urandom_range(40, 1);
      base = -int'($urandom_range(32'h3FFF_FFFF));
      seq_count++;
      for (k = 0; k < len; k++) begin
         case (kind)
            KIND_UNIFORM: value = $urandom();
            // tiny range: lots of equal values hitting existing tails
            KIND_NARROW:  value = int'($urandom_range(15)) - 8;
            KIND_RISING: begin
               // rising with occasional dips that land inside the table
               if ($urandom_range(7) == 0) begin
                  value = base - int'($urandom_range(1 << 22));
               end else begin
                  base  = base + int'($urandom_range(1 << 20));
                  value = base;
               end
            end
            KIND_FALLING: begin
               base  = base - int'($urandom_range(1 << 20));
               value = base;
            end
            default: begin
               case ($urandom_range(6))
                  0:       value = SAMPLE_MIN;
                  1:       value = SAMPLE_MAX;
                  2:       value = SAMPLE_MIN + 1;
                  3:       value = SAMPLE_MAX - 1;
                  4:       value = -1;
                  5:       value = 0;
                  default: value = 1;
               endcase
            end
         endcase
         restart = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(199) == 0);
         send_sample(value, restart);
      end
   endtask

   initial begin
      int drain_cycles;
      int random_start;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table with no start flag, extremes, equal values,
      // restarts. Expected lengths are noted for the maintainer.
      send_sample(0, 1'b0);                  // empty table after reset: 1
      send_sample(SAMPLE_MIN, 1'b1);         // restart: 1
      send_sample(SAMPLE_MAX, 1'b0);         // append: 2
      send_sample(SAMPLE_MAX, 1'b0);         // equal to last tail: 2
      send_sample(SAMPLE_MIN, 1'b0);         // equal to first tail: 1
      send_sample(0, 1'b0);                  // replaces the top: 2
      send_sample(1, 1'b0);                  // 3
      send_sample(-1, 1'b0);                 // 2
      send_sample(-1, 1'b0);                 // equal, mid table: 2
      send_sample(SAMPLE_MAX - 1, 1'b0);     // 4
      send_sample(SAMPLE_MAX, 1'b0);         // 5
      send_sample(32'sh5555_5555, 1'b0);     // 4
      send_sample(SAMPLE_MAX, 1'b1);         // restart at max: 1
      send_sample(SAMPLE_MIN, 1'b0);         // replaces it: 1
      send_sample(32'shAAAA_AAAA, 1'b0);     // 2
      send_sample(32'sh5555_5555, 1'b0);     // 3
      send_sample(SAMPLE_MIN + 1, 1'b0);     // 2
      send_sample(0, 1'b1);                  // restart: 1
      send_sample(-1, 1'b0);                 // 1

      fill_to_overflow();

      random_start = sent_count;
      while (sent_count < random_start + RANDOM_ITEMS)
         random_sequence();
      req_valid <= 1'b0;

      // Let every outstanding transaction come back, then a few more cycles
      // in case something unexpected trails behind.
      repeat (2) @(posedge clock);
      drain_cycles = 0;
      while (pending_count != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (pending_count != 0)
         $display("%0t: %0d expected transactions never arrived", $time, pending_count);
      $display("Covered %0d requests in %0d sequences, one table filled to %0d tails,",
               sent_count, seq_count, DEPTH);
      $display("%0d responses checked, %0d with overflow, under four idling modes.",
               checked_count, overflow_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("%0t: timeout", $time);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/lpt_pkg.sv
sv/lpt_ctrl.sv
sv/lpt_datapath.sv
sv/lis_patience_tails.sv
sv/lpt_checker.sv
tb/lis_patience_tails_checker.sv
tb/lis_patience_tails_tb.sv
